// ===== design/maptp_pkg.sv =====
`default_nettype none

package maptp_pkg;

    // Input transaction: one character of the address text
    typedef struct packed {
        logic [7:0] char_code;
        logic       start_req;
    } char_item_t;

    // Result transaction: parsed address or error flag
    typedef struct packed {
        logic [47:0] mac_address;
        logic        status;
    } addr_item_t;

    // Status codes
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_BAD = 1'b1;

    // Character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;

    // Value of a letter digit is its low bits plus this offset ('A' and 'a' end in 1)
    localparam logic [3:0] LETTER_OFS = 4'd9;

endpackage

`default_nettype wire

// ===== design/mac_address_text_parser.sv =====
`default_nettype none

// Streaming parser for text addresses of OCTETS colon-separated hex groups (1 or 2
// digits each, either case). Send one character per transaction on req; set
// start_req on the first character of an address. One result leaves on rsp when
// the address is complete (status 0, first group in the top byte of the 48 bits)
// or at the first bad character (status 1, address zero); later characters are
// dropped until the next start. The last group ends after its second digit, or
// after one digit at a NUL or whitespace character. One character is taken per
// clock while req_stall is low: it sits in an input register, is decoded against
// the parser state, and any result goes to an output register. A result is
// registered when its character moves on from the input register. req_stall is
// raised only while a result is held in the output register by rsp_stall.
module mac_address_text_parser #(
    parameter int unsigned OCTETS = 6
) (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     req_valid,
    output logic                    req_stall,
    input  maptp_pkg::char_item_t   req,
    output logic                    rsp_valid,
    input  wire                     rsp_stall,
    output maptp_pkg::addr_item_t   rsp
);

    localparam logic [2:0] LAST_GROUP = 3'(OCTETS - 1);

    // Parse phase codes
    localparam logic [1:0] PH_FIRST     = 2'd0;
    localparam logic [1:0] PH_AFTER_ONE = 2'd1;
    localparam logic [1:0] PH_AFTER_TWO = 2'd2;

    // Input stage
    logic                  in_valid_reg;
    maptp_pkg::char_item_t in_reg;

    // Parser state
    logic [2:0]  group_count_reg, group_count_next;
    logic [1:0]  phase_reg, phase_next;
    logic [47:0] addr_shift_reg, addr_shift_next;
    logic [7:0]  cur_group_reg, cur_group_next;
    logic        active_reg, active_next;

    // Output stage
    logic                  out_valid_reg;
    maptp_pkg::addr_item_t out_reg;

    logic                  advance;
    logic                  emit;
    maptp_pkg::addr_item_t result;

    // Move the held character through the parser when the output can take a result
    assign advance   = in_valid_reg && (!out_valid_reg || !rsp_stall);
    assign req_stall = in_valid_reg && !advance;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    // Character decode and state update
    always_comb
    begin
        logic [7:0]  c;
        logic        is_hex;
        logic [3:0]  nib;
        logic        is_ws;
        logic        last;
        logic [2:0]  gc;
        logic [1:0]  ph;
        logic [47:0] ashift;
        logic [7:0]  cg;
        logic        act;
        logic        close;
        logic        bad;
        logic [7:0]  grp;

        c      = in_reg.char_code;
        gc     = group_count_reg;
        ph     = phase_reg;
        ashift = addr_shift_reg;
        cg     = cur_group_reg;
        act    = active_reg;
        close  = 1'b0;
        bad    = 1'b0;
        grp    = cur_group_reg;

        // Restart drops any parse in progress
        if (in_reg.start_req)
        begin
            gc     = '0;
            ph     = PH_FIRST;
            ashift = '0;
            cg     = '0;
            act    = 1'b1;
        end

        is_hex = 1'b0;
        nib    = '0;
        if (c >= maptp_pkg::CH_0 && c <= maptp_pkg::CH_9)
        begin
            is_hex = 1'b1;
            nib    = c[3:0];
        end
        else if ((c >= maptp_pkg::CH_UA && c <= maptp_pkg::CH_UF) ||
                 (c >= maptp_pkg::CH_LA && c <= maptp_pkg::CH_LF))
        begin
            is_hex = 1'b1;
            nib    = c[3:0] + maptp_pkg::LETTER_OFS;
        end
        is_ws = (c == maptp_pkg::CH_SPACE) ||
                (c >= maptp_pkg::CH_TAB && c <= maptp_pkg::CH_CR);
        last  = gc >= LAST_GROUP;

        group_count_next = gc;
        phase_next       = ph;
        addr_shift_next  = ashift;
        cur_group_next   = cg;
        active_next      = act;
        emit             = 1'b0;
        result           = '0;

        if (act)
        begin
            unique case (ph)
                PH_FIRST:
                begin
                    if (!is_hex)
                        bad = 1'b1;
                    else
                    begin
                        cur_group_next = {4'd0, nib};
                        phase_next     = PH_AFTER_ONE;
                    end
                end
                PH_AFTER_ONE:
                begin
                    if (last)
                    begin
                        if (c == maptp_pkg::CH_NUL || is_ws)
                            close = 1'b1;
                        else if (!is_hex)
                            bad = 1'b1;
                        else
                        begin
                            grp   = {cg[3:0], nib};
                            close = 1'b1;
                        end
                    end
                    else if (c == maptp_pkg::CH_COLON)
                        close = 1'b1;
                    else if (!is_hex)
                        bad = 1'b1;
                    else
                    begin
                        cur_group_next = {cg[3:0], nib};
                        phase_next     = PH_AFTER_TWO;
                    end
                end
                default:
                begin
                    if (c != maptp_pkg::CH_COLON)
                        bad = 1'b1;
                    else
                        close = 1'b1;
                end
            endcase

            // Append finished group; complete the address after the last one
            if (close)
            begin
                addr_shift_next = {ashift[39:0], grp};
                cur_group_next  = '0;
                phase_next      = PH_FIRST;
                if (last)
                begin
                    active_next        = 1'b0;
                    emit               = 1'b1;
                    result.mac_address = {ashift[39:0], grp};
                    result.status      = maptp_pkg::STATUS_OK;
                end
                else
                    group_count_next = gc + 3'd1;
            end

            if (bad)
            begin
                active_next        = 1'b0;
                emit               = 1'b1;
                result.mac_address = '0;
                result.status      = maptp_pkg::STATUS_BAD;
            end
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (!req_stall)
            in_valid_reg <= req_valid;
    end

    always_ff @(posedge clk)
    begin
        if (!req_stall && req_valid)
            in_reg <= req;
    end

    // Parser state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_count_reg <= '0;
            phase_reg       <= PH_FIRST;
            addr_shift_reg  <= '0;
            cur_group_reg   <= '0;
            active_reg      <= 1'b0;
        end
        else if (advance)
        begin
            group_count_reg <= group_count_next;
            phase_reg       <= phase_next;
            addr_shift_reg  <= addr_shift_next;
            cur_group_reg   <= cur_group_next;
            active_reg      <= active_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (!out_valid_reg || !rsp_stall)
            out_valid_reg <= advance && emit;
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
            out_reg <= result;
    end

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

module tb;

    localparam int unsigned OCTETS      = 6;
    localparam int unsigned CYCLE_LIMIT = 400000;
    // Random text runs until this many characters have been sent in total;
    // the full-rate tail adds roughly another 120
    localparam int unsigned RAND_CHARS  = 930;
    localparam int unsigned DRAIN_WAIT  = 8;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned MAX_PRINTS  = 50;

    typedef enum logic [1:0] {PH_FIRST, PH_AFTER_ONE, PH_AFTER_TWO} parse_phase_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  req_valid = 1'b0;
    logic                  req_stall;
    maptp_pkg::char_item_t req       = '0;
    logic                  rsp_valid;
    logic                  rsp_stall = 1'b0;
    maptp_pkg::addr_item_t rsp;

    // Parser state as tracked by the testbench
    logic [2:0]   grp_idx  = '0;
    parse_phase_t phase    = PH_FIRST;
    logic [47:0]  addr_acc = '0;
    logic [7:0]   grp_val  = '0;
    logic         parsing  = 1'b0;

    maptp_pkg::addr_item_t addr_expect_q[$];
    logic [7:0]  text_q[$];
    int unsigned err_cnt    = 0;
    int unsigned sent_chars = 0;
    int unsigned cyc_cnt    = 0;
    int unsigned hold_len   = 0;
    bit          idle_on    = 1'b0;

    mac_address_text_parser #(
        .OCTETS(OCTETS)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp      (rsp)
    );

    always #5 clk = ~clk;

    // Run limit
    always @(posedge clk)
    begin
        cyc_cnt <= cyc_cnt + 1;
        if (cyc_cnt == CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic flag_mismatch(input string msg);
        err_cnt++;
        if (err_cnt <= MAX_PRINTS)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    function automatic int hex_nibble(input logic [7:0] c);
        if (c >= maptp_pkg::CH_0 && c <= maptp_pkg::CH_9)
            return int'(c - maptp_pkg::CH_0);
        if (c >= maptp_pkg::CH_UA && c <= maptp_pkg::CH_UF)
            return int'(c - maptp_pkg::CH_UA) + 10;
        if (c >= maptp_pkg::CH_LA && c <= maptp_pkg::CH_LF)
            return int'(c - maptp_pkg::CH_LA) + 10;
        return -1;
    endfunction

    function automatic bit is_blank(input logic [7:0] c);
        return c == maptp_pkg::CH_SPACE || (c >= maptp_pkg::CH_TAB && c <= maptp_pkg::CH_CR);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
        if (n < 4'd10)
            return maptp_pkg::CH_0 + 8'(n);
        return (upper ? maptp_pkg::CH_UA : maptp_pkg::CH_LA) + 8'(n) - 8'd10;
    endfunction

    // Bad character: parse ends with an error transaction
    task automatic expect_bad();
        parsing = 1'b0;
        addr_expect_q.push_back('{mac_address: 48'd0, status: maptp_pkg::STATUS_BAD});
    endtask

    // Shift the finished group in; emit the address after the last group
    task automatic close_group();
        addr_acc = {addr_acc[39:0], grp_val};
        grp_val  = '0;
        phase    = PH_FIRST;
        if (grp_idx >= OCTETS - 1)
        begin
            parsing = 1'b0;
            addr_expect_q.push_back('{mac_address: addr_acc, status: maptp_pkg::STATUS_OK});
        end
        else
            grp_idx = grp_idx + 3'd1;
    endtask

    // Advance the parser by one accepted character
    task automatic predict_char(input maptp_pkg::char_item_t item);
        logic [7:0] c;
        bit         last;
        int         nib;
        c = item.char_code;
        if (item.start_req)
        begin
            grp_idx  = '0;
            phase    = PH_FIRST;
            addr_acc = '0;
            grp_val  = '0;
            parsing  = 1'b1;
        end
        if (!parsing)
            return;
        last = (grp_idx >= OCTETS - 1);
        nib  = hex_nibble(c);
        case (phase)
            PH_FIRST:
            begin
                if (nib < 0)
                    expect_bad();
                else
                begin
                    grp_val = 8'(nib);
                    phase   = PH_AFTER_ONE;
                end
            end
            PH_AFTER_ONE:
            begin
                if (last && (c == maptp_pkg::CH_NUL || is_blank(c)))
                    close_group();
                else if (!last && c == maptp_pkg::CH_COLON)
                    close_group();
                else if (nib < 0)
                    expect_bad();
                else
                begin
                    grp_val = {grp_val[3:0], 4'(nib)};
                    if (last)
                        close_group();
                    else
                        phase = PH_AFTER_TWO;
                end
            end
            default:
            begin
                if (c != maptp_pkg::CH_COLON)
                    expect_bad();
                else
                    close_group();
            end
        endcase
    endtask

    // Offer one character, with an occasional gap first; valid stays high after
    task automatic send_char(input logic [7:0] ch, input logic st);
        maptp_pkg::char_item_t item;
        item.char_code = ch;
        item.start_req = st;
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        req       <= item;
        req_valid <= 1'b1;
        do @(posedge clk); while (req_stall);
        sent_chars++;
        predict_char(item);
    endtask

    task automatic send_string(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], i == 0);
    endtask

    task automatic send_text_q();
        foreach (text_q[i])
            send_char(text_q[i], i == 0);
    endtask

    // Sender stops until every pending result has been taken
    task automatic wait_drained();
        req_valid <= 1'b0;
        do @(posedge clk); while (addr_expect_q.size() != 0);
    endtask

    // Well-formed address text with random digits, case and terminator
    task automatic make_address_text();
        int ndig;
        int k;
        text_q.delete();
        for (int g = 0; g < OCTETS; g++)
        begin
            ndig = $urandom_range(1, 2);
            repeat (ndig)
                text_q.push_back(hex_char(4'($urandom), 1'($urandom_range(0, 1))));
            if (g < OCTETS - 1)
                text_q.push_back(maptp_pkg::CH_COLON);
            else if (ndig == 1)
            begin
                k = $urandom_range(0, 6);
                if (k == 0)
                    text_q.push_back(maptp_pkg::CH_NUL);
                else if (k == 1)
                    text_q.push_back(maptp_pkg::CH_SPACE);
                else
                    text_q.push_back(maptp_pkg::CH_TAB + 8'(k - 2));
            end
            else if ($urandom_range(0, 2) == 0)
                text_q.push_back(8'($urandom));
        end
    endtask

    // Result checker
    always @(posedge clk)
    begin
        maptp_pkg::addr_item_t exp_item;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (addr_expect_q.size() == 0)
                flag_mismatch($sformatf("unexpected result addr=%h status=%b",
                                        rsp.mac_address, rsp.status));
            else
            begin
                exp_item = addr_expect_q.pop_front();
                if (rsp.mac_address !== exp_item.mac_address)
                    flag_mismatch($sformatf("mac_address %h, expected %h",
                                            rsp.mac_address, exp_item.mac_address));
                if (rsp.status !== exp_item.status)
                    flag_mismatch($sformatf("status %b, expected %b",
                                            rsp.status, exp_item.status));
            end
        end
    end

    // Receiver: random stall bursts, plus a long hold on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_len != 0)
            begin
                rsp_stall <= 1'b1;
                repeat (hold_len) @(posedge clk);
                hold_len = 0;
                rsp_stall <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 9) == 0)
            begin
                rsp_stall <= 1'b1;
                repeat ($urandom_range(1, 17)) @(posedge clk);
                rsp_stall <= 1'b0;
            end
        end
    end

    // Characters with no parse running are dropped
    task automatic test_idle_chars();
        send_char(8'hFF, 1'b0);
        send_char(maptp_pkg::CH_0, 1'b0);
    endtask

    // Single-digit groups of both cases, last one ended by whitespace
    task automatic test_short_groups();
        send_string("F:0:a:9:B:e ");
        send_char(maptp_pkg::CH_COLON, 1'b0);
    endtask

    // Non-ASCII, NUL and an early terminator are bad characters
    task automatic test_bad_chars();
        send_char(8'h80, 1'b1);
        send_char(8'hFF, 1'b1);
        send_char(maptp_pkg::CH_NUL, 1'b1);
        send_string("0 ");
    endtask

    // A new start drops the parse in progress
    task automatic test_restart();
        send_string("a:");
        send_char(8'hFF, 1'b1);
    endtask

    // Receiver holds off while the sender keeps offering, then the sender pauses
    task automatic test_backpressure();
        idle_on  = 1'b0;
        hold_len = HOLD_CYCLES;
        repeat (4)
        begin
            make_address_text();
            send_text_q();
        end
        wait_drained();
        idle_on = 1'b1;
    endtask

    // Mostly well-formed addresses, some corrupted, some line noise
    task automatic test_random_text();
        int sel;
        int pos;
        while (sent_chars < RAND_CHARS)
        begin
            sel = $urandom_range(0, 9);
            if (sel < 9)
            begin
                make_address_text();
                if (sel >= 6)
                begin
                    pos = $urandom_range(0, text_q.size() - 1);
                    case ($urandom_range(0, 2))
                        0: text_q[pos] = 8'($urandom);
                        1: text_q = text_q[0:pos];
                        default: text_q.insert(pos, 8'($urandom));
                    endcase
                end
                send_text_q();
            end
            else
            begin
                repeat ($urandom_range(1, 8))
                    send_char(8'($urandom), $urandom_range(0, 15) == 0);
            end
            // trailing character, usually ignored
            if ($urandom_range(0, 3) == 0)
                send_char(8'($urandom), 1'b0);
            if ($urandom_range(0, 39) == 0)
                idle_on = ~idle_on;
            if ($urandom_range(0, 49) == 0)
                wait_drained();
        end
        idle_on = 1'b1;
    endtask

    // Closing stretch at full rate on both sides
    task automatic test_full_rate_tail();
        idle_on = 1'b0;
        repeat (8)
        begin
            make_address_text();
            send_text_q();
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        idle_on = 1'b1;

        test_idle_chars();
        test_short_groups();
        test_bad_chars();
        test_restart();
        test_backpressure();
        test_random_text();
        test_full_rate_tail();

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (err_cnt == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== files.f =====
design/maptp_pkg.sv
design/mac_address_text_parser.sv
tb/sv/tb.sv
